/* rtl/wujs_pkg.sv */
package wujs_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int VAL_W       = 16;
  localparam int ENT_W       = 2 * VAL_W;
  localparam int PEN_W       = 40;

  typedef enum logic [1:0] {
    OP_ARRIVE = 2'd0,
    OP_TICK   = 2'd1,
    OP_FINISH = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH1,
    ST_FLUSH2,
    ST_TAKE,
    ST_WRLAST,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic scan_start;
    logic scan_step;
    logic take;
    logic rd_last;
    logic wr_last;
    logic ld_res;
  } cmd_t;

  typedef struct packed {
    logic needs_scan;
    logic op_tick;
    logic cnt_last;
    logic best_one;
    logic out_free;
  } sts_t;

endpackage

/* rtl/wujs_ram.sv */
module wujs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/wujs_ctrl.sv */
module wujs_ctrl
  import wujs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid && sts.out_free && sts.needs_scan) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.cnt_last) state_next = ST_FLUSH1;
      end
      ST_FLUSH1: state_next = ST_FLUSH2;
      ST_FLUSH2: state_next = sts.op_tick ? ST_TAKE : ST_DONE;
      ST_TAKE:   state_next = sts.best_one ? ST_WRLAST : ST_DONE;
      ST_WRLAST: state_next = ST_DONE;
      ST_DONE: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready       = sts.out_free;
        cmd.accept     = s_tvalid && sts.out_free;
        cmd.scan_start = s_tvalid && sts.out_free && sts.needs_scan;
      end
      ST_SCAN:   cmd.scan_step = 1'b1;
      ST_TAKE: begin
        cmd.take    = !sts.best_one;
        cmd.rd_last = sts.best_one;
      end
      ST_WRLAST: cmd.wr_last = 1'b1;
      ST_DONE:   cmd.ld_res  = sts.out_free;
      default:   cmd = '0;
    endcase
  end

endmodule

/* rtl/wujs_dp.sv */
module wujs_dp
  import wujs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       in_op,
  input  logic [VAL_W-1:0] in_weight,
  input  logic [VAL_W-1:0] in_units,
  input  cmd_t             cmd,
  output sts_t             sts,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_served,
  output logic [VAL_W-1:0] out_sw,
  output logic             out_full,
  output logic [PEN_W-1:0] out_pen,
  output logic [OCC_W-1:0] out_pend
);

  localparam logic [OCC_W-1:0] DEPTH_C = OCC_W'(QUEUE_DEPTH);

  logic [OCC_W-1:0] occ;
  logic [IDX_W-1:0] cnt;
  op_t              op_q;
  logic             rd_v;
  logic [IDX_W-1:0] rd_idx;
  logic [VAL_W-1:0] best_w, best_u;
  logic [IDX_W-1:0] best_idx;
  logic [ENT_W-1:0] prod;
  logic             prod_v;
  logic [PEN_W-1:0] acc;
  logic [PEN_W:0]   acc_sum;

  logic             we, re;
  logic [IDX_W-1:0] waddr, raddr, last_idx;
  logic [ENT_W-1:0] wdata, rdata;
  logic [VAL_W-1:0] dw, du;
  logic             better, arrive_ok, arrive_full;
  op_t              op_in;

  assign op_in       = op_t'(in_op);
  assign last_idx    = IDX_W'(occ - 1'b1);
  assign dw          = rdata[VAL_W-1:0];
  assign du          = rdata[ENT_W-1:VAL_W];
  assign better      = (dw > best_w) || ((dw == best_w) && (du > best_u));
  assign arrive_ok   = (op_in == OP_ARRIVE) && (in_units != '0) && (occ < DEPTH_C);
  assign arrive_full = (op_in == OP_ARRIVE) && (in_units != '0) && (occ >= DEPTH_C);
  assign acc_sum     = {1'b0, acc} + (PEN_W + 1)'(prod);

  assign sts.needs_scan = (occ != '0) && ((op_in == OP_TICK) || (op_in == OP_FINISH));
  assign sts.op_tick    = (op_q == OP_TICK);
  assign sts.cnt_last   = (cnt == last_idx);
  assign sts.best_one   = (best_u == VAL_W'(1));
  assign sts.out_free   = !out_valid || out_ready;

  always_comb begin
    we    = 1'b0;
    waddr = best_idx;
    wdata = rdata;
    if (cmd.accept && arrive_ok) begin
      we    = 1'b1;
      waddr = occ[IDX_W-1:0];
      wdata = {in_units, in_weight};
    end else if (cmd.take) begin
      we    = 1'b1;
      wdata = {best_u - 1'b1, best_w};
    end else if (cmd.wr_last) begin
      we    = 1'b1;
    end
    re    = cmd.scan_step || cmd.rd_last;
    raddr = cmd.rd_last ? last_idx : cnt;
  end

  wujs_ram #(.WIDTH(ENT_W), .DEPTH(QUEUE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      occ       <= '0;
      rd_v      <= 1'b0;
      prod_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_v   <= cmd.scan_step;
      prod_v <= rd_v && (op_q == OP_FINISH);
      if (cmd.accept && arrive_ok) occ <= occ + 1'b1;
      if (cmd.wr_last) occ <= occ - 1'b1;
      if (cmd.ld_res && (op_q == OP_FINISH)) occ <= '0;
      if ((cmd.accept && !sts.needs_scan) || cmd.ld_res) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // scan datapath and result word
  always_ff @(posedge clk) begin
    if (cmd.accept) op_q <= op_in;
    if (cmd.scan_start) begin
      cnt <= '0;
      acc <= '0;
    end
    if (cmd.scan_step) cnt <= cnt + 1'b1;
    rd_idx <= cnt;
    if (rd_v && (op_q == OP_TICK) && ((rd_idx == '0) || better)) begin
      best_w   <= dw;
      best_u   <= du;
      best_idx <= rd_idx;
    end
    prod <= ENT_W'(dw) * ENT_W'(du);
    if (prod_v) acc <= acc_sum[PEN_W] ? {PEN_W{1'b1}} : acc_sum[PEN_W-1:0];
    if (cmd.accept && !sts.needs_scan) begin
      out_served <= 1'b0;
      out_sw     <= '0;
      out_full   <= arrive_full;
      out_pen    <= '0;
      out_pend   <= arrive_ok ? occ + 1'b1 : occ;
    end else if (cmd.ld_res) begin
      out_served <= (op_q == OP_TICK);
      out_sw     <= (op_q == OP_TICK) ? best_w : '0;
      out_full   <= 1'b0;
      out_pen    <= (op_q == OP_FINISH) ? acc : '0;
      out_pend   <= (op_q == OP_FINISH) ? '0 : occ;
    end
  end

endmodule

/* rtl/weighted_unit_job_scheduler_unit.sv */
// Weighted job scheduler. Up to QUEUE_DEPTH (64) jobs sit in one RAM, each
// as a weight and a remaining unit count. s_tuser carries the operation
// (arrive, tick, finish); every input word yields exactly one output word.
// Arrive, unknown operations and tick/finish on an empty queue complete in
// the accept cycle. A tick or a finish walks the RAM over the N pending
// jobs, one entry per cycle through its single read port; when the served
// job of a tick empties, the last entry is moved into its slot. A new word
// is taken only when the output register is empty or is being read in the
// same cycle.
module weighted_unit_job_scheduler_unit
  import wujs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // job_weight[15:0], job_units[31:16]
  input  logic [1:0]  s_tuser,  // operation[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata   // served[0], served_weight[16:1], queue_full[17],
                                // total_penalty[57:18], pending_jobs[64:58], zero pad
);

  cmd_t             cmd;
  sts_t             sts;
  logic             served, full;
  logic [VAL_W-1:0] sw;
  logic [PEN_W-1:0] pen;
  logic [OCC_W-1:0] pend;

  wujs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  wujs_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_op      (s_tuser),
    .in_weight  (s_tdata[15:0]),
    .in_units   (s_tdata[31:16]),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_served (served),
    .out_sw     (sw),
    .out_full   (full),
    .out_pen    (pen),
    .out_pend   (pend)
  );

  assign m_tdata = {7'd0, pend, pen, full, sw, served};

  // a served tick never reports a dropped arrive
  a_served_not_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> !m_tdata[17]) else $error("served and full together");

  // pending count never exceeds the queue depth
  a_pend_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[64:58] <= OCC_W'(QUEUE_DEPTH))) else $error("pending too large");

  // no new word while a scan is running
  a_no_accept_in_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step |-> !s_tready) else $error("accept during scan");

  // finish result always reports an empty queue
  a_finish_empties: assert property (@(posedge clk) disable iff (rst)
    cmd.ld_res && !sts.op_tick |=> (m_tdata[64:58] == '0)) else $error("finish left jobs");

endmodule

/* tb/sv/weighted_unit_job_scheduler_unit_tb.sv */
module weighted_unit_job_scheduler_unit_tb;
  import wujs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [6:0]  pending_jobs;
    logic [39:0] total_penalty;
    logic        queue_full;
    logic [15:0] served_weight;
    logic        served;
  } sched_res_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // job_weight[15:0], job_units[31:16]
  logic [1:0]  s_tuser;   // operation[1:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [71:0] m_tdata;   // served, served_weight, queue_full, total_penalty, pending_jobs

  weighted_unit_job_scheduler_unit u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // shadow copy of the job store
  logic [15:0] job_wt [QUEUE_DEPTH];
  logic [15:0] job_cnt [QUEUE_DEPTH];
  int          job_num;
  sched_res_t  sched_q [$];

  int send_idle_pct;
  int recv_idle_pct;
  int recv_hold;     // long output stall, in cycles
  int mismatches;

  // expected word for one accepted input word; updates the shadow store
  function automatic sched_res_t schedule_item(op_t op, logic [15:0] w, logic [15:0] u);
    sched_res_t r;
    int best;
    logic [63:0] pen;
    r = '0;
    case (op)
      OP_ARRIVE: begin
        if (u != 0) begin
          if (job_num >= QUEUE_DEPTH) r.queue_full = 1'b1;
          else begin
            job_wt[job_num] = w;
            job_cnt[job_num] = u;
            job_num++;
          end
        end
      end
      OP_TICK: begin
        if (job_num > 0) begin
          best = 0;
          for (int i = 1; i < job_num; i++)
            if (job_wt[i] > job_wt[best] ||
                (job_wt[i] == job_wt[best] && job_cnt[i] > job_cnt[best])) best = i;
          r.served = 1'b1;
          r.served_weight = job_wt[best];
          job_cnt[best] = job_cnt[best] - 16'd1;
          if (job_cnt[best] == 0) begin
            job_num--;
            job_wt[best] = job_wt[job_num];
            job_cnt[best] = job_cnt[job_num];
          end
        end
      end
      OP_FINISH: begin
        pen = 0;
        for (int i = 0; i < job_num; i++) begin
          pen += job_wt[i] * job_cnt[i];
          if (pen > 64'hFF_FFFF_FFFF) pen = 64'hFF_FFFF_FFFF;
        end
        r.total_penalty = pen[39:0];
        job_num = 0;
      end
      default: ;
    endcase
    r.pending_jobs = job_num[6:0];
    return r;
  endfunction

  // offer one word, hold it until accepted; valid stays high into the next word
  task automatic send_word(op_t op, logic [15:0] w, logic [15:0] u);
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {u, w};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sched_q = {sched_q, schedule_item(op, w, u)};
  endtask

  // receiver: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if (recv_hold > 0) begin
      recv_hold <= recv_hold - 1;
      m_tready <= 1'b0;
    end else
      m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
  end

  // result checker
  always @(posedge clk) begin
    sched_res_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = sched_res_t'(m_tdata[64:0]);
      if (sched_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output word %h", m_tdata);
      end else begin
        want = sched_q.pop_front();
        if (got !== want || m_tdata[71:65] !== '0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp srv=%0b sw=%0d full=%0b pen=%0d pend=%0d | got srv=%0b sw=%0d full=%0b pen=%0d pend=%0d",
                     want.served, want.served_weight, want.queue_full, want.total_penalty,
                     want.pending_jobs, got.served, got.served_weight, got.queue_full,
                     got.total_penalty, got.pending_jobs);
        end
      end
    end
  end

  function automatic logic [15:0] rand_val();
    case ($urandom_range(3, 0))
      0: return 16'hFFFF;
      1: return 16'($urandom_range(4, 1));
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic test_directed();
    send_word(OP_TICK, 16'h0, 16'h0);         // empty tick
    send_word(OP_FINISH, 16'h0, 16'h0);       // empty finish
    send_word(OP_NONE, 16'hFFFF, 16'hFFFF);   // unknown operation
    send_word(OP_ARRIVE, 16'h1234, 16'h0);    // zero units, ignored
    send_word(OP_ARRIVE, 16'hFFFF, 16'hFFFF);
    send_word(OP_ARRIVE, 16'hFFFF, 16'h0002); // weight tie, fewer units
    send_word(OP_ARRIVE, 16'h0000, 16'h0001);
    send_word(OP_ARRIVE, 16'h0007, 16'h0001);
    send_word(OP_ARRIVE, 16'h0007, 16'h0001); // equal jobs
    send_word(OP_TICK, 16'h0, 16'h0);
    send_word(OP_TICK, 16'h0, 16'h0);
    send_word(OP_NONE, 16'h0, 16'h0);
    send_word(OP_FINISH, 16'h0, 16'h0);
    send_word(OP_ARRIVE, 16'h0003, 16'h0001);
    send_word(OP_TICK, 16'h0, 16'h0);         // job leaves queue
    send_word(OP_TICK, 16'h0, 16'h0);
  endtask

  // fill to full, drop extras, zero-unit arrive on a full queue, drain a bit
  task automatic test_full_queue();
    for (int i = 0; i < QUEUE_DEPTH; i++) send_word(OP_ARRIVE, rand_val(), rand_val());
    send_word(OP_ARRIVE, 16'hFFFF, 16'hFFFF);
    send_word(OP_ARRIVE, 16'h0001, 16'h0000);
    for (int i = 0; i < 6; i++) send_word(OP_TICK, 16'h0, 16'h0);
    send_word(OP_FINISH, 16'h0, 16'h0);
  endtask

  task automatic test_random(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99, 0);
      if (k < 45) send_word(OP_ARRIVE, rand_val(), rand_val());
      else if (k < 88) send_word(OP_TICK, 16'($urandom()), 16'($urandom()));
      else if (k < 96) send_word(OP_FINISH, 16'($urandom()), 16'($urandom()));
      else send_word(OP_NONE, 16'($urandom()), 16'($urandom()));
    end
  endtask

  // output held off while input keeps coming, so the block backs up
  task automatic test_backpressure();
    recv_hold = 300;
    test_random(20);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sched_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = OP_NONE;
    m_tready = 1'b0;
    job_num = 0;
    mismatches = 0;
    recv_hold = 0;
    send_idle_pct = 22;
    recv_idle_pct = 62;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_queue();
    test_backpressure();
    test_random(130);
    send_idle_pct = 62;
    recv_idle_pct = 22;
    test_random(130);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(130);
    drain();
    if (mismatches == 0 && sched_q.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

/* filelist.f */
rtl/wujs_pkg.sv
rtl/wujs_ram.sv
rtl/wujs_ctrl.sv
rtl/wujs_dp.sv
rtl/weighted_unit_job_scheduler_unit.sv
tb/sv/weighted_unit_job_scheduler_unit_tb.sv
